### rtl/u3wd_pkg.sv
// ============================================================================
// u3wd_pkg: shared types and constants of the uniform 3x3 window detector
// Holds the geometry constants, the transaction payload structs and the
// small structs that travel between the line buffer, window and top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package u3wd_pkg;

   // Grid geometry.
   localparam int MAX_WIDTH = 16;
   localparam int MAX_ROWS  = 2048;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int SYM_W   = 8;
   localparam int MATCH_W = 16;

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 5;
   localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(12);
   localparam logic             REG_ROW_WIDTH   = 1'b0;   // word index bit of paddr
   localparam int               MIN_WIDTH       = 3;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_of_grid;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] centre_row;
      logic [4:0]  centre_col;
      logic [7:0]  centre_symbol;
      logic [15:0] match_total;
   } rsp_payload_type;

   // One column of the window: top is two rows above, bot is the newest row.
   typedef struct packed {
      logic [SYM_W-1:0] top;
      logic [SYM_W-1:0] mid;
      logic [SYM_W-1:0] bot;
   } column_type;

   // Contents of one line buffer column.
   typedef struct packed {
      logic [SYM_W-1:0] two_above;
      logic [SYM_W-1:0] above;
   } line_entry_type;

endpackage

`default_nettype wire

### rtl/uniform_3x3_window_detector.sv
// ============================================================================
// uniform_3x3_window_detector: uniform 3x3 neighborhood detector
// Streams a raster grid of symbols, keeps two line buffers and a 3x3
// window, and reports every interior cell whose eight neighbors all match it.
// ============================================================================
//
// Usage:
// The req channel carries one grid symbol per transaction in raster order,
// with last_of_grid set on the final symbol of a grid. The rsp channel
// carries one transaction for every window whose nine symbols are equal:
// the 1-based row and column of the window center, the symbol and the
// running match count of the grid (saturating at 65535).
// The row width comes from the row_width register (byte address 0) of the
// APB-style csr port; values below 3 act as 3 and above 16 act as 16.
// A result is registered at the edge that accepts its symbol. Throughput
// is one symbol per cycle while req_stall is low; the line buffer column
// read, the window shift and the eight compares all happen in the same cycle.
// Results land in an output register backed by a one-entry skid register,
// so a symbol is still accepted while one result waits on a stalled rsp
// channel; req_stall rises only once the skid register is occupied too.
// Synchronous reset clears the line buffers, the window, the position and
// match counters, both result valid bits, and sets row_width back to 12.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module uniform_3x3_window_detector (
   input  wire                                    clock,
   input  wire                                    reset,
   // Input channel.
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  u3wd_pkg::req_payload_type              req_payload,
   // Result channel.
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output u3wd_pkg::rsp_payload_type              rsp_payload,
   // Configuration port.
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [u3wd_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire  [u3wd_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [u3wd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   // -------------------------------------------------------------------------
   // Configuration register. Bit 2 of the address selects the word; the only
   // register lives at word zero, and the low two bits are byte offsets.
   // -------------------------------------------------------------------------
   logic [u3wd_pkg::CFG_W-1:0] row_width_ff;
   logic [u3wd_pkg::CFG_W-1:0] row_width_in;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_width_in = row_width_ff;
      if (csr_write && (csr_paddr[2] == u3wd_pkg::REG_ROW_WIDTH)) begin
         row_width_in = csr_pwdata[u3wd_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == u3wd_pkg::REG_ROW_WIDTH) begin
         csr_prdata = u3wd_pkg::CSR_DATA_W'(row_width_ff);
      end
   end

   // Clamp the programmed width to the range the line buffers support.
   logic [u3wd_pkg::WID_W-1:0] eff_width;

   always_comb begin
      if (32'(row_width_ff) < u3wd_pkg::MIN_WIDTH) begin
         eff_width = u3wd_pkg::WID_W'(u3wd_pkg::MIN_WIDTH);
      end else if (32'(row_width_ff) > u3wd_pkg::MAX_WIDTH) begin
         eff_width = u3wd_pkg::WID_W'(u3wd_pkg::MAX_WIDTH);
      end else begin
         eff_width = u3wd_pkg::WID_W'(row_width_ff);
      end
   end

   // -------------------------------------------------------------------------
   // Handshake.
   // -------------------------------------------------------------------------
   logic req_accept;
   logic skid_valid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   // -------------------------------------------------------------------------
   // Position and match counters.
   // -------------------------------------------------------------------------
   logic [u3wd_pkg::COL_W-1:0]   col_ff,   col_in;
   logic [u3wd_pkg::ROW_W-1:0]   row_ff,   row_in;
   logic [u3wd_pkg::MATCH_W-1:0] match_ff, match_in;
   logic [u3wd_pkg::MATCH_W-1:0] match_next;
   logic [u3wd_pkg::WID_W-1:0]   col_plus_one;

   assign col_plus_one = u3wd_pkg::WID_W'(col_ff) + u3wd_pkg::WID_W'(1);

   // -------------------------------------------------------------------------
   // Line buffer: one cell per column; only the current column is written.
   // -------------------------------------------------------------------------
   u3wd_pkg::line_entry_type line_entry [u3wd_pkg::MAX_WIDTH];
   u3wd_pkg::line_entry_type line_rd;

   for (genvar gi = 0; gi < u3wd_pkg::MAX_WIDTH; gi++) begin : g_line
      u3wd_line_cell u_line_cell (
         .clock  (clock),
         .reset  (reset),
         .wr_en  (req_accept && (col_ff == u3wd_pkg::COL_W'(gi))),
         .symbol (req_payload.symbol),
         .entry  (line_entry[gi])
      );
   end

   always_comb begin
      line_rd = '0;
      for (int i = 0; i < u3wd_pkg::MAX_WIDTH; i++) begin
         if (col_ff == u3wd_pkg::COL_W'(i)) begin
            line_rd = line_entry[i];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Window: three column cells, the newest on the right. Each accepted
   // transaction shifts every column one place to the left and brings in the
   // buffered column plus the incoming symbol.
   // -------------------------------------------------------------------------
   u3wd_pkg::column_type new_col;
   u3wd_pkg::column_type win_col [3];

   assign new_col.top = line_rd.two_above;
   assign new_col.mid = line_rd.above;
   assign new_col.bot = req_payload.symbol;

   u3wd_win_cell u_win_cell0 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .col_in   (win_col[1]),
      .col_out  (win_col[0])
   );

   u3wd_win_cell u_win_cell1 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .col_in   (win_col[2]),
      .col_out  (win_col[1])
   );

   u3wd_win_cell u_win_cell2 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_accept),
      .col_in   (new_col),
      .col_out  (win_col[2])
   );

   // The window after this shift is {win_col[1], win_col[2], new_col}; its
   // center is the middle symbol of what is now the newest stored column.
   logic [u3wd_pkg::SYM_W-1:0] centre;
   logic                       uniform;
   logic                       interior;
   logic                       hit;

   assign centre = win_col[2].mid;

   always_comb begin
      uniform = (win_col[1].top == centre) && (win_col[1].mid == centre) &&
                (win_col[1].bot == centre) && (win_col[2].top == centre) &&
                (win_col[2].bot == centre) && (new_col.top == centre) &&
                (new_col.mid == centre)    && (new_col.bot == centre);
   end

   assign interior = (row_ff >= u3wd_pkg::ROW_W'(2)) && (col_ff >= u3wd_pkg::COL_W'(2));
   assign hit      = req_accept && interior && uniform;

   assign match_next = (match_ff != '1) ? (match_ff + u3wd_pkg::MATCH_W'(1)) : match_ff;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      match_in = match_ff;
      if (req_accept) begin
         if (hit) begin
            match_in = match_next;
         end
         // The row ends once the column reaches the last column of the
         // current width, also when the width shrank within the row.
         if (col_plus_one >= eff_width) begin
            col_in = '0;
            if (row_ff != u3wd_pkg::ROW_W'(u3wd_pkg::MAX_ROWS - 1)) begin
               row_in = row_ff + u3wd_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_plus_one[u3wd_pkg::COL_W-1:0];
         end
         if (req_payload.last_of_grid) begin
            col_in   = '0;
            row_in   = '0;
            match_in = '0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result register with a skid register behind it.
   // -------------------------------------------------------------------------
   u3wd_pkg::rsp_payload_type new_rsp;
   u3wd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   u3wd_pkg::rsp_payload_type skid_payload_ff, skid_payload_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      skid_valid_in;
   logic                      out_free;

   assign new_rsp.centre_row    = 12'(row_ff);
   assign new_rsp.centre_col    = 5'(col_ff);
   assign new_rsp.centre_symbol = centre;
   assign new_rsp.match_total   = match_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      skid_valid_in   = skid_valid_ff;
      skid_payload_in = skid_payload_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // No transaction is accepted while the skid register is full.
            rsp_valid_in   = 1'b1;
            rsp_payload_in = skid_payload_ff;
            skid_valid_in  = 1'b0;
         end else begin
            rsp_valid_in   = hit;
            rsp_payload_in = new_rsp;
         end
      end else if (hit) begin
         skid_valid_in   = 1'b1;
         skid_payload_in = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= u3wd_pkg::ROW_WIDTH_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         match_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         match_ff      <= match_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff  <= rsp_payload_in;
      skid_payload_ff <= skid_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> $past(rsp_stall))
      else $error("skid register filled without a stalled result channel");

   a_grid_end_clears : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.last_of_grid) |=>
         (col_ff == '0 && row_ff == '0 && match_ff == '0))
      else $error("position or match count not cleared after the end of a grid");

   a_result_counted : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.match_total != '0))
      else $error("result transaction carries a zero match count");

endmodule

`default_nettype wire

### rtl/u3wd_line_cell.sv
// ============================================================================
// u3wd_line_cell: one column of the two line buffers
// On a write the older row takes the newer one and the newer row takes the
// incoming symbol, so the two previous rows of that column are kept.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module u3wd_line_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              wr_en,
   input  wire  [u3wd_pkg::SYM_W-1:0]       symbol,
   output u3wd_pkg::line_entry_type         entry
);

   u3wd_pkg::line_entry_type entry_ff;
   u3wd_pkg::line_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in.two_above = entry_ff.above;
         entry_in.above     = symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

### rtl/u3wd_win_cell.sv
// ============================================================================
// u3wd_win_cell: one column of the 3x3 window
// Takes the column of its newer neighbor on every accepted transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module u3wd_win_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        shift_en,
   input  u3wd_pkg::column_type       col_in,
   output u3wd_pkg::column_type       col_out
);

   u3wd_pkg::column_type col_ff;
   u3wd_pkg::column_type col_in_mux;

   assign col_in_mux = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_mux;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

### test/u3wd_checker.sv
// ============================================================================
// u3wd_checker: result predictor and scoreboard of the window detector
// Watches the req, rsp and csr ports, predicts every match from its own copy
// of the line buffers, window and counters, and compares each rsp transaction.
// ============================================================================
`timescale 1ns / 1ps

module u3wd_checker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_stall,
   input  u3wd_pkg::req_payload_type     req_payload,
   input  wire                           rsp_valid,
   input  wire                           rsp_stall,
   input  u3wd_pkg::rsp_payload_type     rsp_payload,
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire  [u3wd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [u3wd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire                           csr_pready,
   output int                            error_count,
   output int                            outstanding
);

   localparam logic [u3wd_pkg::CSR_ADDR_W-1:0] ROW_WIDTH_ADDR =
      {u3wd_pkg::REG_ROW_WIDTH, 2'b00};

   logic [u3wd_pkg::CFG_W-1:0] row_width_reg;
   logic [7:0]                 prev_row      [u3wd_pkg::MAX_WIDTH];
   logic [7:0]                 prev_prev_row [u3wd_pkg::MAX_WIDTH];
   logic [7:0]                 neighborhood  [9];
   int                         col_pos;
   int                         row_pos;
   int                         grid_matches;
   u3wd_pkg::rsp_payload_type  expected_matches [$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // Shift one symbol into the window and queue the match it completes, if any.
   task automatic advance_window(input u3wd_pkg::req_payload_type item);
      int                        span;
      int                        slot;
      bit                        uniform;
      u3wd_pkg::rsp_payload_type hit;
      span = int'(row_width_reg);
      if (span < u3wd_pkg::MIN_WIDTH) span = u3wd_pkg::MIN_WIDTH;
      if (span > u3wd_pkg::MAX_WIDTH) span = u3wd_pkg::MAX_WIDTH;
      slot = col_pos % u3wd_pkg::MAX_WIDTH;
      for (int k = 0; k < 6; k++) neighborhood[k] = neighborhood[k+3];
      neighborhood[6] = prev_prev_row[slot];
      neighborhood[7] = prev_row[slot];
      neighborhood[8] = item.symbol;
      prev_prev_row[slot] = prev_row[slot];
      prev_row[slot] = item.symbol;
      uniform = 1'b1;
      for (int k = 0; k < 9; k++)
         if (neighborhood[k] != neighborhood[4]) uniform = 1'b0;
      if (row_pos >= 2 && col_pos >= 2 && uniform) begin
         if (grid_matches < 65535) grid_matches++;
         hit.centre_row    = 12'(row_pos);
         hit.centre_col    = 5'(col_pos);
         hit.centre_symbol = neighborhood[4];
         hit.match_total   = 16'(grid_matches);
         expected_matches.push_back(hit);
      end
      if (col_pos + 1 >= span) begin
         col_pos = 0;
         if (row_pos < u3wd_pkg::MAX_ROWS - 1) row_pos++;
      end else begin
         col_pos++;
      end
      if (item.last_of_grid) begin
         col_pos = 0;
         row_pos = 0;
         grid_matches = 0;
      end
   endtask

   always @(posedge clock) begin
      u3wd_pkg::rsp_payload_type want;
      if (reset) begin
         row_width_reg = u3wd_pkg::ROW_WIDTH_RESET;
         for (int k = 0; k < u3wd_pkg::MAX_WIDTH; k++) begin
            prev_row[k] = '0;
            prev_prev_row[k] = '0;
         end
         for (int k = 0; k < 9; k++) neighborhood[k] = '0;
         col_pos = 0;
         row_pos = 0;
         grid_matches = 0;
         expected_matches.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ROW_WIDTH_ADDR)
            row_width_reg = csr_pwdata[u3wd_pkg::CFG_W-1:0];

         // A result on the wire belongs to an earlier symbol, so it is
         // checked before the symbol of this edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_payload);
               error_count++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_payload.centre_row != want.centre_row) begin
                  $display("%0t: centre_row mismatch, expected %0d, actual %0d",
                           $time, want.centre_row, rsp_payload.centre_row);
                  error_count++;
               end
               if (rsp_payload.centre_col != want.centre_col) begin
                  $display("%0t: centre_col mismatch, expected %0d, actual %0d",
                           $time, want.centre_col, rsp_payload.centre_col);
                  error_count++;
               end
               if (rsp_payload.centre_symbol != want.centre_symbol) begin
                  $display("%0t: centre_symbol mismatch, expected %h, actual %h",
                           $time, want.centre_symbol, rsp_payload.centre_symbol);
                  error_count++;
               end
               if (rsp_payload.match_total != want.match_total) begin
                  $display("%0t: match_total mismatch, expected %0d, actual %0d",
                           $time, want.match_total, rsp_payload.match_total);
                  error_count++;
               end
            end
         end

         if (req_valid && !req_stall) advance_window(req_payload);
      end
      outstanding <= expected_matches.size();
   end

endmodule

### test/tb_uniform_3x3_window_detector.sv
// ============================================================================
// tb_uniform_3x3_window_detector: stimulus and verdict for the detector
// Drives grids of symbols under several row widths with random bursts and
// rsp stalls, while the checker predicts and compares every match.
// ============================================================================
`timescale 1ns / 1ps

module tb_uniform_3x3_window_detector;

   // The block registers a result at the edge that accepts its symbol, so an
   // idle stretch of SETTLE_CYCLES after the last result suffices before a csr write.
   localparam int SETTLE_CYCLES = 4;
   // Length of the one long rsp hold-off; far beyond the two result
   // registers, so the block has to stall its input.
   localparam int HOLD_CYCLES   = 300;
   // Rows of the uniform full-width grid that is sent with no sender gaps:
   // width 16 gives 14 matches per row from the third row on.
   localparam int FULL_ROWS     = 3;
   localparam int RANDOM_ITEMS  = 350;

   localparam logic [u3wd_pkg::CSR_ADDR_W-1:0] ROW_WIDTH_ADDR =
      {u3wd_pkg::REG_ROW_WIDTH, 2'b00};

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   u3wd_pkg::req_payload_type           req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   u3wd_pkg::rsp_payload_type           rsp_payload;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [u3wd_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [u3wd_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [u3wd_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   int error_count;
   int outstanding;

   // Handshake between the stimulus and the receiver: the stimulus raises
   // the flag, the receiver lowers it once the long hold-off is over.
   bit hold_pending = 1'b0;
   // Gaps between bursts are switched off for the full-width grid.
   bit gaps_on      = 1'b1;
   int burst_left   = 0;
   // Row width the block works with, after clamping to 3..16.
   int cur_span     = 12;
   int random_sent  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   uniform_3x3_window_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   u3wd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Offers one symbol and returns at the edge that accepts it. The sender
   // works in bursts; between bursts valid drops for a random gap. Valid is
   // only lowered when a gap really follows, so it never gets two
   // assignments in one time step.
   task automatic send_symbol(input logic [7:0] symbol, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid                <= 1'b1;
      req_payload.symbol       <= symbol;
      req_payload.last_of_grid <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every predicted match has come back,
   // then lets the block go quiet for the SETTLE_CYCLES stretch.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes row_width through a setup and an access phase. The upper data
   // bits carry noise that the register has to ignore.
   task automatic write_row_width(input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROW_WIDTH_ADDR;
      csr_pwdata  <= {27'($urandom_range(0, 32'h7FF_FFFF)), 5'(value)};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_span = value & 5'h1F;
      if (cur_span < u3wd_pkg::MIN_WIDTH) cur_span = u3wd_pkg::MIN_WIDTH;
      if (cur_span > u3wd_pkg::MAX_WIDTH) cur_span = u3wd_pkg::MAX_WIDTH;
   endtask

   // One grid in raster order. Most symbols repeat the base symbol so that
   // uniform windows are common; purity sets how often. A grid may end early
   // on a stray last_of_grid, or run on without one, in which case the next
   // grid continues from the same position.
   task automatic send_grid(input int rows, input logic [7:0] base, input int purity,
                            input bit close_grid);
      int          total;
      logic [7:0]  symbol;
      bit          last;
      total = rows * cur_span;
      for (int n = 0; n < total; n++) begin
         symbol = ($urandom_range(0, 99) < purity) ? base : 8'($urandom);
         last = (close_grid && n == total - 1) || ($urandom_range(0, 99) < 2);
         send_symbol(symbol, last);
         random_sent++;
         if (last) break;
      end
   endtask

   // Receiver: stalls on a pattern of its own that changes every random
   // stretch (never, rarely, mostly, alternating), apart from the one long
   // hold-off that the stimulus asks for.
   initial begin : receiver
      int mode;
      int stretch;
      bit toggle;
      mode    = 0;
      stretch = 0;
      toggle  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end
         if (stretch == 0) begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(1, 40);
         end
         stretch--;
         toggle = !toggle;
         case (mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= toggle;
            end
         endcase
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int         phase_widths [7];
      int         phase_count;
      logic [7:0] base;
      int         purity;

      phase_widths = '{16, 0, 31, 5, 2, 17, 9};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the narrowest width. A uniform 3x3 grid of all ones
      // gives exactly one match at row 2, column 2.
      write_row_width(3);
      for (int n = 0; n < 9; n++) send_symbol(8'hFF, n == 8);
      // An all-zero grid whose center differs in its top bit: no match.
      for (int n = 0; n < 9; n++) send_symbol((n == 4) ? 8'h80 : 8'h00, n == 8);
      // A grid that ends after its second symbol, in the middle of a row.
      send_symbol(8'hAA, 1'b0);
      send_symbol(8'h55, 1'b1);
      send_symbol(8'hAA, 1'b0);
      send_symbol(8'hAA, 1'b0);
      send_symbol(8'hAA, 1'b1);

      // The sender pauses until everything has come back, then the receiver
      // holds off for a long stretch while a uniform grid keeps coming, so
      // both result registers fill and the block stalls its input.
      settle();
      hold_pending = 1'b1;
      for (int n = 0; n < 30; n++) send_symbol(8'h3C, n == 29);
      settle();

      // Random part: several row widths, in range and out of range. Widths
      // change between phases while a row may still be open.
      for (int p = 0; p < 7; p++) begin
         if (p == 6) phase_widths[p] = $urandom_range(0, 31);
         write_row_width(phase_widths[p]);
         phase_count = random_sent;
         while (random_sent - phase_count < RANDOM_ITEMS / 7) begin
            base   = 8'($urandom);
            // One grid in ten is pure noise; the rest are mostly uniform.
            purity = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(80, 97);
            send_grid($urandom_range(3, 5), base, purity, $urandom_range(0, 9) != 0);
         end
         settle();
      end

      // One uniform grid at full width with no sender gaps, so symbols and
      // matches follow each other back to back.
      write_row_width(16);
      gaps_on = 1'b0;
      for (int n = 0; n < FULL_ROWS * 16; n++) send_symbol(8'hC3, n == FULL_ROWS * 16 - 1);
      gaps_on = 1'b1;
      settle();

      // Back to the reset width for a last short grid.
      write_row_width(12);
      send_grid(4, 8'h0F, 90, 1'b1);
      settle();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
